// File: hw/rtl/icalu_pkg.sv
// Shared constants, datapath command codes and status bundle of the integer calculator ALU.
package icalu_pkg;

   localparam int DATA_WIDTH_DEF = 32;

   // A Fibonacci run never holds more results than this.
   localparam int FIB_MAX   = 47;
   localparam int FIB_CNT_W = 6;

   localparam logic [3:0] OP_GCD3  = 4'd0;
   localparam logic [3:0] OP_LCM3  = 4'd1;
   localparam logic [3:0] OP_FACT  = 4'd2;
   localparam logic [3:0] OP_FIB   = 4'd3;
   localparam logic [3:0] OP_ADD   = 4'd4;
   localparam logic [3:0] OP_SUB   = 4'd5;
   localparam logic [3:0] OP_MUL   = 4'd6;
   localparam logic [3:0] OP_DIV   = 4'd7;
   localparam logic [3:0] OP_REM   = 4'd8;
   localparam logic [3:0] OP_POW   = 4'd9;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_DIVZ = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   typedef enum logic [5:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_GCD_AB,
      CMD_GCD_C,
      CMD_DIV_XY,
      CMD_GCD_STEP,
      CMD_LCM_AB,
      CMD_LCM_C,
      CMD_DIV_UX,
      CMD_MUL_QV,
      CMD_LCM_END,
      CMD_ZERO,
      CMD_FACT_INIT,
      CMD_MUL_ACC_Y,
      CMD_FACT_STEP,
      CMD_FACT_BIG,
      CMD_POW_INIT,
      CMD_MUL_ACC_X,
      CMD_POW_RMUL,
      CMD_MUL_X_X,
      CMD_POW_SQ,
      CMD_POW_NEG,
      CMD_DIV_AB,
      CMD_MUL_AB,
      CMD_FIB_INIT,
      CMD_FIB_EMIT,
      CMD_OUT_GCD,
      CMD_OUT_ACC,
      CMD_OUT_ADD,
      CMD_OUT_SUB,
      CMD_OUT_MUL,
      CMD_OUT_DIV,
      CMD_OUT_REM,
      CMD_OUT_POW
   } dp_cmd_type;

   typedef struct packed {
      logic a_neg;
      logic a_zero;
      logic b_neg;
      logic b_zero;
      logic fact_big;
      logic y_zero;
      logic y_odd;
      logic lcm_zero;
      logic fact_more;
      logic fib_last;
      logic div_done;
      logic mul_done;
   } dp_status_type;

endpackage

// File: hw/rtl/icalu_mul.sv
// Shift-and-add unsigned multiplier, one multiplier bit per cycle.
module icalu_mul import icalu_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DW-1:0]     mcand,
   input  logic [DW-1:0]     mplier,
   output logic [2*DW-1:0]   prod,
   output logic              done
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0]   cnt_ff;
   logic            done_ff;
   logic [2*DW-1:0] mc_ff;
   logic [DW-1:0]   mp_ff;
   logic [2*DW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CW'(DW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         mc_ff  <= {{DW{1'b0}}, mcand};
         mp_ff  <= mplier;
      end else if (cnt_ff != '0) begin
         if (mp_ff[0]) begin
            acc_ff <= acc_ff + mc_ff;
         end
         mc_ff <= mc_ff << 1;
         mp_ff <= mp_ff >> 1;
      end
   end

   assign prod = acc_ff;
   assign done = done_ff;

endmodule

// File: hw/rtl/icalu_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module icalu_div import icalu_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic [DW-1:0] quo,
   output logic [DW-1:0] rem,
   output logic          done
);

   localparam int CW = $clog2(DW + 1);

   logic [CW-1:0] cnt_ff;
   logic          done_ff;
   logic [DW-1:0] q_ff;
   logic [DW-1:0] r_ff;
   logic [DW-1:0] d_ff;
   logic [DW:0]   shifted;
   logic [DW:0]   diff;

   assign shifted = {r_ff, q_ff[DW-1]};
   assign diff    = shifted - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CW'(DW);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (cnt_ff != '0) begin
         // A borrow out of the trial subtraction means the divisor did not fit.
         if (!diff[DW]) begin
            r_ff <= diff[DW-1:0];
            q_ff <= {q_ff[DW-2:0], 1'b1};
         end else begin
            r_ff <= shifted[DW-1:0];
            q_ff <= {q_ff[DW-2:0], 1'b0};
         end
      end
   end

   assign quo  = q_ff;
   assign rem  = r_ff;
   assign done = done_ff;

endmodule

// File: hw/rtl/icalu_dp.sv
// Datapath: operand and work registers, multiplier, divider and result registers.
module icalu_dp import icalu_pkg::*; #(
   parameter int DW = DATA_WIDTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   input  logic [31:0]   operand_a,
   input  logic [31:0]   operand_b,
   input  logic [31:0]   operand_c,
   output dp_status_type dp_status,
   output logic [31:0]   result,
   output logic [1:0]    status,
   output logic          last_result
);

   localparam logic [DW-1:0] DSIGN = {1'b1, {(DW-1){1'b0}}};
   localparam logic [DW-1:0] DMAXP = {1'b0, {(DW-1){1'b1}}};

   function automatic logic [DW-1:0] mag(input logic [DW-1:0] v);
      return v[DW-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DW-1:0] load_op(input logic [31:0] v);
      logic signed [63:0] e;
      e = 64'(signed'(v));
      return e[DW-1:0];
   endfunction

   function automatic logic [31:0] to_port(input logic [DW-1:0] v);
      logic signed [63:0] e;
      e = 64'(signed'(v));
      return e[31:0];
   endfunction

   logic [DW-1:0] opa_ff, opb_ff, opc_ff;
   logic [DW-1:0] x_ff, y_ff, u_ff, v_ff, acc_ff;
   logic          ovf_ff, rbig_ff, bbig_ff;
   logic [FIB_CNT_W-1:0] fcnt_ff;
   logic [31:0]   res_ff;
   logic [1:0]    st_ff;
   logic          last_ff;

   logic [DW-1:0]   ma, mb, mc;
   logic [DW-1:0]   mul_a, mul_b, div_n, div_d;
   logic            mul_go, div_go;
   logic [2*DW-1:0] prod;
   logic [DW-1:0]   plo, phi, quo, rem;
   logic            mul_done, div_done;
   logic            fib_cont;

   logic            out_load;
   logic [DW-1:0]   res_w;
   logic [1:0]      st_w;
   logic            last_w;
   logic [DW-1:0]   sum, dif;
   logic            neg_w;
   logic [DW-1:0]   lim_w;

   assign ma  = mag(opa_ff);
   assign mb  = mag(opb_ff);
   assign mc  = mag(opc_ff);
   assign plo = prod[DW-1:0];
   assign phi = prod[2*DW-1:DW];
   assign sum = opa_ff + opb_ff;
   assign dif = opa_ff - opb_ff;

   assign fib_cont = !opa_ff[DW-1] && (opa_ff > v_ff) &&
                     (fcnt_ff < FIB_CNT_W'(FIB_MAX - 1));

   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_go = 1'b0;
      div_n  = '0;
      div_d  = '0;
      div_go = 1'b0;
      case (cmd)
         CMD_MUL_AB:    begin mul_a = ma;     mul_b = mb;   mul_go = 1'b1; end
         CMD_MUL_QV:    begin mul_a = quo;    mul_b = v_ff; mul_go = 1'b1; end
         CMD_MUL_ACC_Y: begin mul_a = acc_ff; mul_b = y_ff; mul_go = 1'b1; end
         CMD_MUL_ACC_X: begin mul_a = acc_ff; mul_b = x_ff; mul_go = 1'b1; end
         CMD_MUL_X_X:   begin mul_a = x_ff;   mul_b = x_ff; mul_go = 1'b1; end
         CMD_DIV_AB:    begin div_n = ma;     div_d = mb;   div_go = 1'b1; end
         CMD_DIV_XY:    begin div_n = x_ff;   div_d = y_ff; div_go = 1'b1; end
         CMD_DIV_UX:    begin div_n = u_ff;   div_d = x_ff; div_go = 1'b1; end
         default: begin
         end
      endcase
   end

   icalu_mul #(.DW(DW)) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_go),
      .mcand  (mul_a),
      .mplier (mul_b),
      .prod   (prod),
      .done   (mul_done)
   );

   icalu_div #(.DW(DW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_go),
      .dividend (div_n),
      .divisor  (div_d),
      .quo      (quo),
      .rem      (rem),
      .done     (div_done)
   );

   // Result selection for the commands that present a transaction on the result ports.
   always_comb begin
      out_load = 1'b1;
      res_w    = acc_ff;
      st_w     = ST_OK;
      last_w   = 1'b1;
      neg_w    = 1'b0;
      lim_w    = DMAXP;
      case (cmd)
         CMD_OUT_GCD: begin
            res_w = x_ff;
            st_w  = x_ff[DW-1] ? ST_OVF : ST_OK;
         end
         CMD_OUT_ACC: begin
            st_w = ovf_ff ? ST_OVF : ST_OK;
         end
         CMD_OUT_ADD: begin
            res_w = sum;
            st_w  = ((opa_ff[DW-1] == opb_ff[DW-1]) && (sum[DW-1] != opa_ff[DW-1]))
                    ? ST_OVF : ST_OK;
         end
         CMD_OUT_SUB: begin
            res_w = dif;
            st_w  = ((opa_ff[DW-1] != opb_ff[DW-1]) && (dif[DW-1] != opa_ff[DW-1]))
                    ? ST_OVF : ST_OK;
         end
         CMD_OUT_MUL: begin
            neg_w = opa_ff[DW-1] ^ opb_ff[DW-1];
            lim_w = neg_w ? DSIGN : DMAXP;
            res_w = neg_w ? (~plo + 1'b1) : plo;
            st_w  = ((phi != '0) || (plo > lim_w)) ? ST_OVF : ST_OK;
         end
         CMD_OUT_DIV: begin
            neg_w = opa_ff[DW-1] ^ opb_ff[DW-1];
            lim_w = neg_w ? DSIGN : DMAXP;
            if (opb_ff == '0) begin
               res_w = '0;
               st_w  = ST_DIVZ;
            end else begin
               res_w = neg_w ? (~quo + 1'b1) : quo;
               st_w  = (quo > lim_w) ? ST_OVF : ST_OK;
            end
         end
         CMD_OUT_REM: begin
            if (opb_ff == '0) begin
               res_w = '0;
               st_w  = ST_DIVZ;
            end else begin
               res_w = opa_ff[DW-1] ? (~rem + 1'b1) : rem;
            end
         end
         CMD_OUT_POW: begin
            neg_w = opa_ff[DW-1] & opb_ff[0];
            lim_w = neg_w ? DSIGN : DMAXP;
            res_w = neg_w ? (~acc_ff + 1'b1) : acc_ff;
            st_w  = (rbig_ff || (acc_ff > lim_w)) ? ST_OVF : ST_OK;
         end
         CMD_FIB_EMIT: begin
            res_w  = u_ff;
            last_w = !fib_cont;
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff  <= '0;
         st_ff   <= ST_OK;
         last_ff <= 1'b0;
      end else if (out_load) begin
         res_ff  <= to_port(res_w);
         st_ff   <= st_w;
         last_ff <= last_w;
      end
      case (cmd)
         CMD_LOAD: begin
            opa_ff  <= load_op(operand_a);
            opb_ff  <= load_op(operand_b);
            opc_ff  <= load_op(operand_c);
            acc_ff  <= DW'(1);
            ovf_ff  <= 1'b0;
            rbig_ff <= 1'b0;
            bbig_ff <= 1'b0;
         end
         CMD_GCD_AB: begin
            x_ff <= ma;
            y_ff <= mb;
         end
         CMD_GCD_C: begin
            y_ff <= mc;
         end
         CMD_GCD_STEP: begin
            x_ff <= y_ff;
            y_ff <= rem;
         end
         CMD_LCM_AB: begin
            u_ff <= ma;
            x_ff <= ma;
            v_ff <= mb;
            y_ff <= mb;
         end
         CMD_LCM_C: begin
            u_ff <= acc_ff;
            x_ff <= acc_ff;
            v_ff <= mc;
            y_ff <= mc;
         end
         CMD_LCM_END, CMD_FACT_STEP: begin
            acc_ff <= plo;
            if ((phi != '0) || plo[DW-1]) begin
               ovf_ff <= 1'b1;
            end
            if (cmd == CMD_FACT_STEP) begin
               y_ff <= y_ff + 1'b1;
            end
         end
         CMD_ZERO: begin
            acc_ff <= '0;
         end
         CMD_FACT_INIT: begin
            y_ff <= DW'(1);
         end
         CMD_FACT_BIG: begin
            acc_ff <= '0;
            ovf_ff <= 1'b1;
         end
         CMD_POW_INIT: begin
            x_ff <= ma;
            y_ff <= opb_ff;
         end
         CMD_POW_RMUL: begin
            // The true product is at least the base, so an oversized base stays oversized.
            acc_ff  <= plo;
            rbig_ff <= rbig_ff | bbig_ff | (phi != '0);
         end
         CMD_POW_SQ: begin
            x_ff    <= plo;
            bbig_ff <= bbig_ff | (phi != '0);
            y_ff    <= y_ff >> 1;
         end
         CMD_POW_NEG: begin
            // A base of one stays one for any exponent.
            if (opa_ff == '1) begin
               acc_ff <= opb_ff[0] ? '1 : DW'(1);
            end else if (opa_ff == DW'(1)) begin
               acc_ff <= DW'(1);
            end else begin
               acc_ff <= '0;
            end
         end
         CMD_FIB_INIT: begin
            u_ff    <= '0;
            v_ff    <= DW'(1);
            fcnt_ff <= '0;
         end
         CMD_FIB_EMIT: begin
            u_ff    <= v_ff;
            v_ff    <= u_ff + v_ff;
            fcnt_ff <= fcnt_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      dp_status.a_neg     = opa_ff[DW-1];
      dp_status.a_zero    = (opa_ff == '0);
      dp_status.b_neg     = opb_ff[DW-1];
      dp_status.b_zero    = (opb_ff == '0);
      dp_status.fact_big  = (opa_ff >= DW'(2 * DW));
      dp_status.y_zero    = (y_ff == '0);
      dp_status.y_odd     = y_ff[0];
      dp_status.lcm_zero  = (u_ff == '0) || (v_ff == '0);
      dp_status.fact_more = (y_ff <= opa_ff);
      dp_status.fib_last  = !fib_cont;
      dp_status.div_done  = div_done;
      dp_status.mul_done  = mul_done;
   end

   assign result      = res_ff;
   assign status      = st_ff;
   assign last_result = last_ff;

endmodule

// File: hw/rtl/icalu_ctrl.sv
// Controller: sequences datapath commands for each operation and strobes results.
module icalu_ctrl import icalu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [3:0]    opcode,
   input  dp_status_type dp_status,
   output logic          busy,
   output dp_cmd_type    cmd,
   output logic          rsp_strobe
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_GCD_TEST,
      S_GCD_WAIT,
      S_LCM_TEST,
      S_LCM_Q,
      S_LCM_QW,
      S_LCM_MW,
      S_LCM_NEXT,
      S_FACT_TEST,
      S_FACT_W,
      S_POW_TEST,
      S_POW_RW,
      S_POW_SQ,
      S_POW_SW,
      S_MUL_WAIT,
      S_DIV_WAIT,
      S_FIB,
      S_OUT
   } state_type;

   state_type  state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       phase_ff, phase_in;
   logic       strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      phase_in  = phase_ff;
      strobe_in = 1'b0;
      cmd       = CMD_NOP;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd      = CMD_LOAD;
               op_in    = opcode;
               phase_in = 1'b0;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (op_ff)
               OP_GCD3: begin
                  cmd      = CMD_GCD_AB;
                  state_in = S_GCD_TEST;
               end
               OP_LCM3: begin
                  cmd      = CMD_LCM_AB;
                  state_in = S_LCM_TEST;
               end
               OP_FACT: begin
                  if (dp_status.a_neg || dp_status.a_zero) begin
                     state_in = S_OUT;
                  end else if (dp_status.fact_big) begin
                     cmd      = CMD_FACT_BIG;
                     state_in = S_OUT;
                  end else begin
                     cmd      = CMD_FACT_INIT;
                     state_in = S_FACT_TEST;
                  end
               end
               OP_FIB: begin
                  cmd      = CMD_FIB_INIT;
                  state_in = S_FIB;
               end
               OP_ADD, OP_SUB: begin
                  state_in = S_OUT;
               end
               OP_MUL: begin
                  cmd      = CMD_MUL_AB;
                  state_in = S_MUL_WAIT;
               end
               OP_DIV, OP_REM: begin
                  if (dp_status.b_zero) begin
                     state_in = S_OUT;
                  end else begin
                     cmd      = CMD_DIV_AB;
                     state_in = S_DIV_WAIT;
                  end
               end
               OP_POW: begin
                  if (dp_status.b_neg) begin
                     cmd      = CMD_POW_NEG;
                     state_in = S_OUT;
                  end else begin
                     cmd      = CMD_POW_INIT;
                     state_in = S_POW_TEST;
                  end
               end
               default: begin
                  cmd      = CMD_ZERO;
                  state_in = S_OUT;
               end
            endcase
         end
         // Euclid loop, shared by gcd3 and by each pairwise lcm step.
         S_GCD_TEST: begin
            if (dp_status.y_zero) begin
               if (op_ff == OP_LCM3) begin
                  state_in = S_LCM_Q;
               end else if (!phase_ff) begin
                  cmd      = CMD_GCD_C;
                  phase_in = 1'b1;
               end else begin
                  state_in = S_OUT;
               end
            end else begin
               cmd      = CMD_DIV_XY;
               state_in = S_GCD_WAIT;
            end
         end
         S_GCD_WAIT: begin
            if (dp_status.div_done) begin
               cmd      = CMD_GCD_STEP;
               state_in = S_GCD_TEST;
            end
         end
         S_LCM_TEST: begin
            if (dp_status.lcm_zero) begin
               cmd      = CMD_ZERO;
               state_in = S_OUT;
            end else begin
               state_in = S_GCD_TEST;
            end
         end
         S_LCM_Q: begin
            cmd      = CMD_DIV_UX;
            state_in = S_LCM_QW;
         end
         S_LCM_QW: begin
            if (dp_status.div_done) begin
               cmd      = CMD_MUL_QV;
               state_in = S_LCM_MW;
            end
         end
         S_LCM_MW: begin
            if (dp_status.mul_done) begin
               cmd      = CMD_LCM_END;
               state_in = S_LCM_NEXT;
            end
         end
         S_LCM_NEXT: begin
            if (!phase_ff) begin
               cmd      = CMD_LCM_C;
               phase_in = 1'b1;
               state_in = S_LCM_TEST;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FACT_TEST: begin
            if (dp_status.fact_more) begin
               cmd      = CMD_MUL_ACC_Y;
               state_in = S_FACT_W;
            end else begin
               state_in = S_OUT;
            end
         end
         S_FACT_W: begin
            if (dp_status.mul_done) begin
               cmd      = CMD_FACT_STEP;
               state_in = S_FACT_TEST;
            end
         end
         // Square and multiply over the exponent bits, low bit first.
         S_POW_TEST: begin
            if (dp_status.y_zero) begin
               state_in = S_OUT;
            end else if (dp_status.y_odd) begin
               cmd      = CMD_MUL_ACC_X;
               state_in = S_POW_RW;
            end else begin
               cmd      = CMD_MUL_X_X;
               state_in = S_POW_SW;
            end
         end
         S_POW_RW: begin
            if (dp_status.mul_done) begin
               cmd      = CMD_POW_RMUL;
               state_in = S_POW_SQ;
            end
         end
         S_POW_SQ: begin
            cmd      = CMD_MUL_X_X;
            state_in = S_POW_SW;
         end
         S_POW_SW: begin
            if (dp_status.mul_done) begin
               cmd      = CMD_POW_SQ;
               state_in = S_POW_TEST;
            end
         end
         S_MUL_WAIT: begin
            if (dp_status.mul_done) begin
               state_in = S_OUT;
            end
         end
         S_DIV_WAIT: begin
            if (dp_status.div_done) begin
               state_in = S_OUT;
            end
         end
         S_FIB: begin
            cmd       = CMD_FIB_EMIT;
            strobe_in = 1'b1;
            if (dp_status.fib_last) begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            case (op_ff)
               OP_GCD3: cmd = CMD_OUT_GCD;
               OP_ADD:  cmd = CMD_OUT_ADD;
               OP_SUB:  cmd = CMD_OUT_SUB;
               OP_MUL:  cmd = CMD_OUT_MUL;
               OP_DIV:  cmd = CMD_OUT_DIV;
               OP_REM:  cmd = CMD_OUT_REM;
               OP_POW:  cmd = dp_status.b_neg ? CMD_OUT_ACC : CMD_OUT_POW;
               default: cmd = CMD_OUT_ACC;
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         op_ff     <= '0;
         phase_ff  <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_ff     <= op_in;
         phase_ff  <= phase_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;

endmodule

// File: hw/rtl/integer_calculator_alu_core.sv
// Top level of the integer calculator ALU: controller plus datapath.
// One transaction is taken when start is high and busy is low; busy then stays high until
// the last result has been put on the rsp_ ports. Each result is shown for exactly one cycle
// with rsp_strobe, and the receiver cannot stall it. Multiply, divide and remainder wait on the
// shift-and-add multiplier and the restoring divider, which each retire one bit per cycle.
// gcd3 and lcm3 take one divide per Euclid remainder step (roughly 1.5 * DATA_WIDTH steps
// at most), factorial one multiply per factor (up to 2 * DATA_WIDTH - 1 factors), and power
// up to two multiplies per exponent bit. A Fibonacci run delivers one term per cycle, up to
// 47 results, the last marked by rsp_last_result.
module integer_calculator_alu_core import icalu_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_operand_a,
   input  logic [31:0] req_operand_b,
   input  logic [31:0] req_operand_c,
   output logic        rsp_strobe,
   output logic [31:0] rsp_result,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_result
);

   dp_cmd_type    cmd;
   dp_status_type dp_status;

   icalu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .opcode     (req_opcode),
      .dp_status  (dp_status),
      .busy       (busy),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe)
   );

   icalu_dp #(.DW(DATA_WIDTH)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .operand_a   (req_operand_a),
      .operand_b   (req_operand_b),
      .operand_c   (req_operand_c),
      .dp_status   (dp_status),
      .result      (rsp_result),
      .status      (rsp_status),
      .last_result (rsp_last_result)
   );

endmodule

// File: tb/tb_integer_calculator_alu_core.sv
// Self-checking testbench for the integer calculator ALU core: directed and random commands.
`timescale 1ns / 100ps

module tb_integer_calculator_alu_core import icalu_pkg::*;;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam logic [63:0] DMASK = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] DSIGN = 64'h0000_0000_8000_0000;
   localparam logic [63:0] DMAXP = 64'h0000_0000_7FFF_FFFF;

   typedef struct {
      logic [3:0]  opcode;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      bit          drain;
   } command_type;

   typedef struct {
      logic [31:0] result;
      logic [1:0]  status;
      logic        last;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_opcode;
   logic [31:0] req_operand_a;
   logic [31:0] req_operand_b;
   logic [31:0] req_operand_c;
   logic        rsp_strobe;
   logic [31:0] rsp_result;
   logic [1:0]  rsp_status;
   logic        rsp_last_result;

   command_type pending_cmds[$];
   answer_type  expected_answers[$];
   int unsigned mismatches, answers_checked, cmds_sent, idle_cycles;
   int unsigned op_count[16];
   bit       drain_now;
   int       burst_left, gap_left;

   integer_calculator_alu_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .req_operand_c(req_operand_c),
      .rsp_strobe(rsp_strobe), .rsp_result(rsp_result),
      .rsp_status(rsp_status), .rsp_last_result(rsp_last_result)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   function automatic bit is_neg(logic [63:0] x);
      return (x & DSIGN) != 0;
   endfunction

   function automatic logic [63:0] mag(logic [63:0] x);
      return is_neg(x) ? ((64'd0 - x) & DMASK) : (x & DMASK);
   endfunction

   function automatic logic [63:0] gcd_u(logic [63:0] x, logic [63:0] y);
      logic [63:0] t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic logic [63:0] lcm_u(logic [63:0] x, logic [63:0] y, inout bit ovf);
      logic [63:0] q;
      if (x == 0 || y == 0) return 0;
      q = x / gcd_u(x, y);
      if (q > DMAXP / y) ovf = 1;
      return (q * y) & DMASK;
   endfunction

   function automatic logic [63:0] to_signed(logic [63:0] m, bit neg, inout bit ovf);
      if (neg) begin
         if (m > DSIGN) ovf = 1;
         return (64'd0 - m) & DMASK;
      end
      if (m > DMAXP) ovf = 1;
      return m & DMASK;
   endfunction

   function automatic logic [63:0] factorial(logic [63:0] a, inout bit ovf);
      logic [63:0] r, m, k;
      r = 1;
      m = 1;
      if (is_neg(a) || a == 0) return 1;
      if (a >= 64) begin
         ovf = 1;
         return 0;
      end
      for (k = 1; k <= a; k++) begin
         r = r * k;
         if (!ovf) begin
            if (m > DMAXP / k) ovf = 1;
            else m = m * k;
         end
      end
      return r & DMASK;
   endfunction

   function automatic logic [63:0] power(logic [63:0] a, logic [63:0] b, inout bit ovf);
      logic [63:0] r, base, e, ma, lim, m, i;
      r = 1;
      base = a;
      e = b;
      if (a == 1 || b == 0) return 1;
      if (is_neg(b)) return (a == DMASK) ? ((b & 1) != 0 ? DMASK : 1) : 0;
      while (e != 0) begin
         if (e[0]) r = r * base;
         base = base * base;
         e = e >> 1;
      end
      ma = mag(a);
      if (ma >= 2) begin
         if (b >= 32) ovf = 1;
         else begin
            lim = (is_neg(a) && b[0]) ? DSIGN : DMAXP;
            m = 1;
            for (i = 0; i < b; i++) begin
               if (m > lim / ma) begin
                  ovf = 1;
                  break;
               end
               m = m * ma;
            end
         end
      end
      return r & DMASK;
   endfunction

   task automatic add_answer(logic [63:0] r, logic [1:0] st, logic last);
      answer_type ans;
      ans.result = r[31:0];
      ans.status = st;
      ans.last = last;
      expected_answers.push_back(ans);
   endtask

   // Works out every result that one accepted command must produce.
   task automatic predict_answers(logic [3:0] op, logic [31:0] ia, logic [31:0] ib,
                                  logic [31:0] ic);
      logic [63:0] a, b, c, r, fa, fb, t, lim;
      bit ovf;
      logic [1:0] st;
      int n;
      a = {32'd0, ia};
      b = {32'd0, ib};
      c = {32'd0, ic};
      r = 0;
      ovf = 0;
      st = ST_OK;
      case (op)
         OP_GCD3: begin
            r = gcd_u(gcd_u(mag(a), mag(b)), mag(c));
            r = to_signed(r, 0, ovf);
         end
         OP_LCM3: r = lcm_u(lcm_u(mag(a), mag(b), ovf), mag(c), ovf);
         OP_FACT: r = factorial(a, ovf);
         OP_FIB: begin
            fa = 0;
            fb = 1;
            n = 1;
            // A run holds 0 and every term below the limit, capped at the maximum length.
            while (!is_neg(a) && a > fb && n < FIB_MAX) begin
               n++;
               t = fb;
               fb = (fb + fa) & DMASK;
               fa = t;
            end
            add_answer(0, ST_OK, n == 1);
            fa = 0;
            fb = 1;
            for (int k = 1; k < n; k++) begin
               add_answer(fb, ST_OK, k == n - 1);
               t = fb;
               fb = (fb + fa) & DMASK;
               fa = t;
            end
            return;
         end
         OP_ADD: begin
            r = (a + b) & DMASK;
            ovf = (is_neg(a) == is_neg(b)) && (is_neg(r) != is_neg(a));
         end
         OP_SUB: begin
            r = (a - b) & DMASK;
            ovf = (is_neg(a) != is_neg(b)) && (is_neg(r) != is_neg(a));
         end
         OP_MUL: begin
            lim = (is_neg(a) != is_neg(b)) ? DSIGN : DMAXP;
            if (mag(a) != 0 && mag(b) > lim / mag(a)) ovf = 1;
            r = (a * b) & DMASK;
         end
         OP_DIV, OP_REM: begin
            if (b == 0) st = ST_DIVZ;
            else if (op == OP_DIV) r = to_signed(mag(a) / mag(b), is_neg(a) != is_neg(b), ovf);
            else r = to_signed(mag(a) % mag(b), is_neg(a), ovf);
         end
         OP_POW: r = power(a, b, ovf);
         default: r = 0;
      endcase
      if (ovf && st == ST_OK) st = ST_OVF;
      add_answer(r, st, 1'b1);
   endtask

   // Command driver: bursts of back-to-back commands separated by random gaps.
   always @(posedge clock) begin
      command_type cmd;
      bit hold;
      if (reset) begin
         start <= 1'b0;
         req_opcode <= '0;
         req_operand_a <= '0;
         req_operand_b <= '0;
         req_operand_c <= '0;
         burst_left <= 0;
         gap_left <= 0;
      end else begin
         hold = 0;
         if (start && !busy) begin
            predict_answers(req_opcode, req_operand_a, req_operand_b, req_operand_c);
            op_count[req_opcode]++;
            cmds_sent++;
         end else if (start) begin
            hold = 1;
         end
         if (!hold) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               start <= 1'b0;
            end else if (pending_cmds.size() > 0 &&
                         !(pending_cmds[0].drain && expected_answers.size() > 0)) begin
               cmd = pending_cmds.pop_front();
               req_opcode <= cmd.opcode;
               req_operand_a <= cmd.a;
               req_operand_b <= cmd.b;
               req_operand_c <= cmd.c;
               start <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 12);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Result monitor: results cannot be stalled, so every strobe is checked.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result %h status %0d last %b",
                        rsp_result, rsp_status, rsp_last_result);
         end else begin
            want = expected_answers.pop_front();
            answers_checked++;
            if (rsp_result !== want.result || rsp_status !== want.status ||
                rsp_last_result !== want.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: result %h/%0d/%b, expected %h/%0d/%b",
                           rsp_result, rsp_status, rsp_last_result,
                           want.result, want.status, want.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_strobe || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic queue_cmd(logic [3:0] op, logic [31:0] a, logic [31:0] b, logic [31:0] c,
                            bit drain = 0);
      command_type cmd;
      cmd.opcode = op;
      cmd.a = a;
      cmd.b = b;
      cmd.c = c;
      cmd.drain = drain;
      pending_cmds.push_back(cmd);
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2: return 32'($urandom_range(0, 40)) - 32'd20;
         3: return 32'($urandom_range(0, 1000)) - 32'd500;
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'd0;
               default: return 32'd1;
            endcase
         end
         default: return (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
      endcase
   endfunction

   initial begin
      logic [3:0] op;
      logic [31:0] a, b, c;
      reset = 1'b1;
      mismatches = 0;
      answers_checked = 0;
      cmds_sent = 0;
      idle_cycles = 0;
      drain_now = 0;
      foreach (op_count[i]) op_count[i] = 0;

      // Directed commands: extremes and the special cases of each operation.
      queue_cmd(OP_GCD3, 32'd12, -32'd18, 32'd30);
      queue_cmd(OP_GCD3, 32'd0, 32'd0, 32'd0);
      queue_cmd(OP_GCD3, 32'h8000_0000, 32'd0, 32'h8000_0000);
      queue_cmd(OP_LCM3, 32'd4, -32'd6, 32'd10);
      queue_cmd(OP_LCM3, 32'd7, 32'd0, 32'd3);
      queue_cmd(OP_LCM3, 32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'd3);
      queue_cmd(OP_FACT, 32'd0, 32'd0, 32'd0);
      queue_cmd(OP_FACT, -32'd3, 32'd0, 32'd0);
      queue_cmd(OP_FACT, 32'd12, 32'd0, 32'd0);
      queue_cmd(OP_FACT, 32'd13, 32'd0, 32'd0);
      queue_cmd(OP_FACT, 32'd64, 32'd0, 32'd0);
      queue_cmd(OP_FIB, 32'd1, 32'd0, 32'd0);
      queue_cmd(OP_FIB, -32'd5, 32'd0, 32'd0);
      queue_cmd(OP_FIB, 32'h7FFF_FFFF, 32'd0, 32'd0);
      queue_cmd(OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'd0);
      queue_cmd(OP_SUB, 32'h8000_0000, 32'd1, 32'd0);
      queue_cmd(OP_MUL, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
      queue_cmd(OP_MUL, -32'd65536, 32'd32768, 32'd0);
      queue_cmd(OP_DIV, 32'd100, 32'd0, 32'd0);
      queue_cmd(OP_REM, -32'd7, 32'd0, 32'd0);
      queue_cmd(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
      queue_cmd(OP_REM, -32'd7, 32'd3, 32'd0);
      queue_cmd(OP_POW, 32'hFFFF_FFFF, -32'd3, 32'd0);
      queue_cmd(OP_POW, 32'd0, -32'd2, 32'd0);
      queue_cmd(OP_POW, 32'd1, -32'd2, 32'd0);
      queue_cmd(OP_POW, -32'd2, 32'd31, 32'd0);
      queue_cmd(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      for (int i = 0; i < 253; i++) begin
         op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                           : 4'($urandom_range(0, 9));
         a = rand_operand();
         b = rand_operand();
         c = rand_operand();
         if (op == OP_FACT && $urandom_range(0, 2) != 0) a = 32'($urandom_range(0, 70));
         if (op == OP_POW && $urandom_range(0, 2) != 0) b = 32'($urandom_range(0, 35));
         if (op == OP_FIB && $urandom_range(0, 1) != 0) a = 32'($urandom_range(0, 5000));
         queue_cmd(op, a, b, c, i == 0 || i == 140);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_cmds.size() != 0 || start || expected_answers.size() != 0)
         @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d commands (gcd %0d, lcm %0d, fact %0d, fib %0d, pow %0d, other %0d),",
               cmds_sent, op_count[0], op_count[1], op_count[2], op_count[3], op_count[9],
               cmds_sent - op_count[0] - op_count[1] - op_count[2] - op_count[3] - op_count[9]);
      $display("checked %0d results, %0d mismatches.", answers_checked, mismatches);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
